[rtl/mmrs_pkg.sv]
package mmrs_pkg;

   localparam int MAX_RANGES_DEFAULT = 4096;
   localparam int MAX_RESULTS        = 5;
   localparam int PAGE_SHIFT         = 12;
   localparam int RANGE_COUNT_W      = 13;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [12:0] RANGE_CAPACITY_RESET = 13'd4096;

   // entry kinds
   localparam logic [15:0] KIND_MEMORY   = 16'd0;
   localparam logic [15:0] KIND_RESERVED = 16'd1;

   // result status codes
   localparam logic [1:0] ST_RANGE   = 2'd0;
   localparam logic [1:0] ST_END     = 2'd1;
   localparam logic [1:0] ST_ERROR   = 2'd2;
   localparam logic [1:0] ST_STOPPED = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_CONTEXT_PAGE  = 2'd0;
   localparam logic [1:0] CSR_MONITOR_BASE  = 2'd1;
   localparam logic [1:0] CSR_MONITOR_SIZE  = 2'd2;
   localparam logic [1:0] CSR_RANGE_CAP     = 2'd3;

   typedef enum logic [1:0] {
      PH_FRESH,
      PH_RUN,
      PH_STOP
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_INIT,
      BK_PASS,
      BK_FIND
   } back_state_type;

   // classified entry as it sits in the queue
   typedef struct packed {
      logic [63:0] start_page;
      logic [63:0] end_page;
      logic        count_zero;
      logic        malformed;
      logic        reserved_kind;
   } item_type;

   typedef struct packed {
      logic [63:0] context_page;
      logic [63:0] monitor_base_bytes;
      logic [63:0] monitor_size_bytes;
      logic [12:0] range_capacity;
   } cfg_type;

endpackage

[rtl/mmrs_front.sv]
module mmrs_front
   import mmrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_start_page,
   input  logic [63:0] req_page_total,
   input  logic [15:0] req_entry_kind,
   output logic        q_valid,
   input  logic        q_pop,
   output item_type    q_item
);

   logic [64:0] sum;
   item_type    item;
   item_type    slot_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;

   // classify: end page, wrap and kind checks need only the entry itself
   assign sum = {1'b0, req_start_page} + {1'b0, req_page_total};

   always_comb begin
      item.start_page    = req_start_page;
      item.end_page      = sum[63:0];
      item.count_zero    = (req_page_total == 64'd0);
      item.malformed     = sum[64] ||
                           ((req_entry_kind != KIND_MEMORY) && (req_entry_kind != KIND_RESERVED));
      item.reserved_kind = (req_entry_kind == KIND_RESERVED);
   end

   assign req_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/mmrs_back.sv]
module mmrs_back
   import mmrs_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_base_address,
   output logic [63:0] rsp_length_bytes,
   output logic        rsp_is_reserved,
   output logic [1:0]  rsp_status,
   output logic [12:0] rsp_ranges_emitted,
   output logic        rsp_last
);

   localparam int CW   = $clog2(MAX_RANGES + 1);
   localparam int CAPW = (CW > RANGE_COUNT_W) ? CW : RANGE_COUNT_W;

   back_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic [63:0]    prev_end_ff, prev_end_in;
   logic [63:0]    hole_base_ff, hole_base_in;
   logic [63:0]    hole_end_ff, hole_end_in;
   logic [CW-1:0]  emitted_ff, emitted_in, emitted_inc;
   logic [63:0]    base_ff, base_in;
   logic [63:0]    end_ff, end_in;
   logic [2:0]     nres_ff, nres_in;
   logic           found_ff, found_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    rsp_base_ff, rsp_base_in;
   logic [63:0]    rsp_len_ff, rsp_len_in;
   logic           rsp_resv_ff, rsp_resv_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [12:0]    rsp_count_ff, rsp_count_in;
   logic           rsp_last_ff, rsp_last_in;

   logic [64:0]    mon_sum;
   logic           mon_wrap, mon_present;
   logic [63:0]    mon_base_pg, mon_end_pg, ctx_end;
   logic [CAPW-1:0] cap_cfg, cap_max, cap;
   logic           cap_hit, cap_next_hit;
   logic           out_free, bad;

   logic           need_find, overlap, below_hole, inside_end;
   logic [63:0]    sel_hi, pass_len, pass_next_base, pass_prev;
   logic           pass_resv, pass_done, pass_last;

   logic           ctx_hit, mon_hit;
   logic [63:0]    find_base, find_end;

   // shared derived values
   assign mon_sum     = {1'b0, cfg.monitor_base_bytes} + {1'b0, cfg.monitor_size_bytes};
   assign mon_wrap    = mon_sum[64];
   assign mon_present = (cfg.monitor_size_bytes[63:PAGE_SHIFT] != '0);
   assign mon_base_pg = {{PAGE_SHIFT{1'b0}}, cfg.monitor_base_bytes[63:PAGE_SHIFT]};
   assign mon_end_pg  = {{PAGE_SHIFT{1'b0}}, mon_sum[63:PAGE_SHIFT]};
   assign ctx_end     = cfg.context_page + 64'd1;

   assign cap_cfg      = CAPW'(cfg.range_capacity);
   assign cap_max      = CAPW'(MAX_RANGES);
   assign cap          = (cap_cfg < cap_max) ? cap_cfg : cap_max;
   assign emitted_inc  = emitted_ff + CW'(1);
   assign cap_hit      = (CAPW'(emitted_ff) >= cap);
   assign cap_next_hit = (CAPW'(emitted_inc) >= cap);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign bad      = q_item.malformed || (q_item.start_page < prev_end_ff);

   // one split pass over the pending remainder
   assign need_find  = !found_ff && (base_ff >= hole_end_ff);
   assign overlap    = (base_ff < hole_end_ff) && (end_ff > hole_base_ff);
   assign below_hole = (base_ff < hole_base_ff);
   assign inside_end = (end_ff <= hole_end_ff);

   always_comb begin
      sel_hi         = end_ff;
      pass_resv      = 1'b0;
      pass_done      = 1'b1;
      pass_next_base = base_ff;
      pass_prev      = end_ff;
      if (overlap) begin
         priority if (below_hole) begin
            sel_hi         = hole_base_ff;
            pass_done      = 1'b0;
            pass_next_base = hole_base_ff;
            pass_prev      = base_ff;
         end else if (inside_end) begin
            pass_resv = 1'b1;
         end else begin
            sel_hi         = hole_end_ff;
            pass_resv      = 1'b1;
            pass_done      = 1'b0;
            pass_next_base = hole_end_ff;
            pass_prev      = hole_end_ff;
         end
      end
   end

   assign pass_len  = sel_hi - base_ff;
   assign pass_last = pass_done || (nres_ff == 3'(MAX_RESULTS - 1)) || cap_next_hit;

   // nearest hole at or after the pending page
   assign ctx_hit   = (base_ff <= cfg.context_page);
   assign mon_hit   = mon_present && (base_ff < mon_end_pg) &&
                      (mon_base_pg < (ctx_hit ? cfg.context_page : '1));
   assign find_base = mon_hit ? mon_base_pg : (ctx_hit ? cfg.context_page : '1);
   assign find_end  = mon_hit ? mon_end_pg : (ctx_hit ? ctx_end : 64'd0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (phase_ff == PH_FRESH) begin
                  state_in = BK_INIT;
               end else if (phase_ff == PH_RUN && !cap_hit && !q_item.count_zero && !bad &&
                            !q_item.reserved_kind) begin
                  state_in = BK_PASS;
               end
            end
         end
         BK_INIT: begin
            if (!mon_wrap || out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_PASS: begin
            if (need_find) begin
               state_in = BK_FIND;
            end else if (out_free && pass_last) begin
               state_in = BK_IDLE;
            end
         end
         BK_FIND: begin
            state_in = BK_PASS;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and result register
   always_comb begin
      phase_in      = phase_ff;
      prev_end_in   = prev_end_ff;
      hole_base_in  = hole_base_ff;
      hole_end_in   = hole_end_ff;
      emitted_in    = emitted_ff;
      base_in       = base_ff;
      end_in        = end_ff;
      nres_in       = nres_ff;
      found_in      = found_ff;
      q_pop         = 1'b0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_base_in   = rsp_base_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_resv_in   = rsp_resv_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               unique case (phase_ff)
                  PH_STOP: begin
                     if (out_free) begin
                        q_pop         = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_base_in   = '0;
                        rsp_len_in    = '0;
                        rsp_resv_in   = 1'b0;
                        rsp_status_in = ST_STOPPED;
                        rsp_count_in  = 13'(emitted_ff);
                        rsp_last_in   = 1'b1;
                     end
                  end
                  PH_RUN: begin
                     priority if (cap_hit || q_item.count_zero || bad) begin
                        if (out_free) begin
                           q_pop         = 1'b1;
                           phase_in      = PH_STOP;
                           rsp_valid_in  = 1'b1;
                           rsp_base_in   = '0;
                           rsp_len_in    = '0;
                           rsp_resv_in   = 1'b0;
                           rsp_status_in = (cap_hit || q_item.count_zero) ? ST_END : ST_ERROR;
                           rsp_count_in  = 13'(emitted_ff);
                           rsp_last_in   = 1'b1;
                        end
                     end else if (q_item.reserved_kind) begin
                        // platform-reserved entries pass through whole
                        if (out_free) begin
                           q_pop         = 1'b1;
                           prev_end_in   = q_item.end_page;
                           emitted_in    = emitted_inc;
                           rsp_valid_in  = 1'b1;
                           rsp_base_in   = {q_item.start_page[63-PAGE_SHIFT:0],
                                            {PAGE_SHIFT{1'b0}}};
                           rsp_len_in    = q_item.end_page - q_item.start_page;
                           rsp_len_in    = {rsp_len_in[63-PAGE_SHIFT:0], {PAGE_SHIFT{1'b0}}};
                           rsp_resv_in   = 1'b1;
                           rsp_status_in = ST_RANGE;
                           rsp_count_in  = 13'(emitted_inc);
                           rsp_last_in   = 1'b1;
                        end
                     end else begin
                        q_pop    = 1'b1;
                        base_in  = q_item.start_page;
                        end_in   = q_item.end_page;
                        nres_in  = 3'd0;
                        found_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_INIT: begin
            if (mon_wrap) begin
               if (out_free) begin
                  q_pop         = 1'b1;
                  phase_in      = PH_STOP;
                  rsp_valid_in  = 1'b1;
                  rsp_base_in   = '0;
                  rsp_len_in    = '0;
                  rsp_resv_in   = 1'b0;
                  rsp_status_in = ST_ERROR;
                  rsp_count_in  = 13'(emitted_ff);
                  rsp_last_in   = 1'b1;
               end
            end else begin
               if (mon_present && (mon_base_pg < cfg.context_page)) begin
                  hole_base_in = mon_base_pg;
                  hole_end_in  = mon_end_pg;
               end else begin
                  hole_base_in = cfg.context_page;
                  hole_end_in  = ctx_end;
               end
               prev_end_in = '0;
               emitted_in  = '0;
               phase_in    = PH_RUN;
            end
         end
         BK_PASS: begin
            if (!need_find && out_free) begin
               emitted_in    = emitted_inc;
               nres_in       = nres_ff + 3'd1;
               found_in      = 1'b0;
               base_in       = pass_next_base;
               prev_end_in   = pass_prev;
               rsp_valid_in  = 1'b1;
               rsp_base_in   = {base_ff[63-PAGE_SHIFT:0], {PAGE_SHIFT{1'b0}}};
               rsp_len_in    = {pass_len[63-PAGE_SHIFT:0], {PAGE_SHIFT{1'b0}}};
               rsp_resv_in   = pass_resv;
               rsp_status_in = ST_RANGE;
               rsp_count_in  = 13'(emitted_inc);
               rsp_last_in   = pass_last;
            end
         end
         BK_FIND: begin
            hole_base_in = find_base;
            hole_end_in  = find_end;
            found_in     = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      hole_base_ff  <= hole_base_in;
      hole_end_ff   <= hole_end_in;
      base_ff       <= base_in;
      end_ff        <= end_in;
      nres_ff       <= nres_in;
      found_ff      <= found_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_resv_ff   <= rsp_resv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         phase_ff     <= PH_FRESH;
         prev_end_ff  <= '0;
         emitted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         prev_end_ff  <= prev_end_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_base_address   = rsp_base_ff;
   assign rsp_length_bytes   = rsp_len_ff;
   assign rsp_is_reserved    = rsp_resv_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_ranges_emitted = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

[rtl/memory_map_reserved_splitter_top.sv]
// Channel   Direction  Handshake            Beat
// req_      in         req_valid/req_ready  one map entry (start page, page count, kind)
// rsp_      out        rsp_valid/rsp_ready  one range or one status, rsp_last ends an entry
// csr_      in         csr_write_en         one register write, no wait, no read-back
//
// An entry is taken into a two-deep queue whenever the queue has room. A status beat or a
// platform-reserved entry leaves the back end as it is dispatched; a free-memory entry
// is split one range per pass, with a lookup step each time it has to find the next
// reserved hole, and gives at most five ranges. The very first entry after reset first
// goes through a set-up step for the holes.
// Reset is synchronous and clears the queue, the run phase and the result valid bit.
// A stalled result beat holds in the output register while the queue keeps filling.
module memory_map_reserved_splitter_top
   import mmrs_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // input entries
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_start_page,
   input  logic [63:0] req_page_total,
   input  logic [15:0] req_entry_kind,
   // result ranges
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_base_address,
   output logic [63:0] rsp_length_bytes,
   output logic        rsp_is_reserved,
   output logic [1:0]  rsp_status,
   output logic [12:0] rsp_ranges_emitted,
   output logic        rsp_last,
   // register writes
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     q_valid, q_pop;
   item_type q_item;

   // register file: hold values until written
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_CONTEXT_PAGE: cfg_in.context_page       = csr_wdata;
            CSR_MONITOR_BASE: cfg_in.monitor_base_bytes = csr_wdata;
            CSR_MONITOR_SIZE: cfg_in.monitor_size_bytes = csr_wdata;
            CSR_RANGE_CAP:    cfg_in.range_capacity     = csr_wdata[12:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.context_page       <= '0;
         cfg_ff.monitor_base_bytes <= '0;
         cfg_ff.monitor_size_bytes <= '0;
         cfg_ff.range_capacity     <= RANGE_CAPACITY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify entries and queue them
   mmrs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_page (req_start_page),
      .req_page_total (req_page_total),
      .req_entry_kind (req_entry_kind),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_item         (q_item)
   );

   // back: split around holes, track order and capacity, drive results
   mmrs_back #(
      .MAX_RANGES (MAX_RANGES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_base_address   (rsp_base_address),
      .rsp_length_bytes   (rsp_length_bytes),
      .rsp_is_reserved    (rsp_is_reserved),
      .rsp_status         (rsp_status),
      .rsp_ranges_emitted (rsp_ranges_emitted),
      .rsp_last           (rsp_last)
   );

endmodule

[rtl/mmrs_checker.sv]
module mmrs_checker
   import mmrs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_base_address,
   input logic [63:0] rsp_length_bytes,
   input logic        rsp_is_reserved,
   input logic [1:0]  rsp_status,
   input logic [12:0] rsp_ranges_emitted,
   input logic        rsp_last
);

   // a status beat always closes its entry
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_RANGE) |-> rsp_last)
      else $error("status beat without last");

   // a status beat carries no range
   a_status_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_RANGE) |->
         (rsp_base_address == 64'd0) && (rsp_length_bytes == 64'd0) && !rsp_is_reserved)
      else $error("status beat carries range data");

   // a range beat has been counted
   a_range_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_RANGE) |-> (rsp_ranges_emitted != 13'd0))
      else $error("range beat with zero count");

   // stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_base_address) &&
         $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind memory_map_reserved_splitter_top mmrs_checker u_mmrs_checker (.*);

[test/tb_top.sv]
module tb_top;
   import mmrs_pkg::*;

   localparam int STALL_LIMIT = 3000;   // idle cycles before the watchdog trips
   localparam int DRAIN_CYCLES = 30;    // settle time after the last expected beat

   typedef struct {
      logic [63:0] base;
      logic [63:0] len;
      logic        resv;
      logic [1:0]  status;
      logic [12:0] count;
      logic        last;
   } range_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_start_page;
   logic [63:0] req_page_total;
   logic [15:0] req_entry_kind;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_base_address;
   logic [63:0] rsp_length_bytes;
   logic        rsp_is_reserved;
   logic [1:0]  rsp_status;
   logic [12:0] rsp_ranges_emitted;
   logic        rsp_last;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   memory_map_reserved_splitter_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_page     (req_start_page),
      .req_page_total     (req_page_total),
      .req_entry_kind     (req_entry_kind),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_base_address   (rsp_base_address),
      .rsp_length_bytes   (rsp_length_bytes),
      .rsp_is_reserved    (rsp_is_reserved),
      .rsp_status         (rsp_status),
      .rsp_ranges_emitted (rsp_ranges_emitted),
      .rsp_last           (rsp_last),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // ---------------------------------------------------------------
   // Splitter model state: register copies plus the running map state
   // ---------------------------------------------------------------
   logic [63:0] m_context_page;
   logic [63:0] m_mon_base;
   logic [63:0] m_mon_size;
   logic [12:0] m_capacity;
   logic [63:0] m_prev_end;
   logic [63:0] m_hole_base;
   logic [63:0] m_hole_end;
   int          m_emitted;
   phase_type   m_phase;

   range_beat_type expected_ranges[$];   // beats still owed by the block
   int          mismatches;
   int          idle_cycles;
   logic [63:0] next_page;            // lowest start page that keeps the map sorted

   // sender and receiver pacing
   bit tx_steady;
   bit rx_steady;
   int rx_hold;

   // Push one expected beat carrying the current range count.
   function automatic void push_range(logic [63:0] base, logic [63:0] len, logic resv,
                                      logic [1:0] status);
      range_beat_type r;
      r.base   = base;
      r.len    = len;
      r.resv   = resv;
      r.status = status;
      r.count  = m_emitted[12:0];
      r.last   = 1'b0;
      expected_ranges.push_back(r);
   endfunction

   function automatic void emit_pages(logic [63:0] page, logic [63:0] pages, logic resv);
      m_emitted++;
      push_range(page << PAGE_SHIFT, pages << PAGE_SHIFT, resv, ST_RANGE);
   endfunction

   function automatic void close_entry();
      expected_ranges[$].last = 1'b1;
   endfunction

   // Locate the next reserved hole at or above the given page.
   function automatic void locate_hole(logic [63:0] page);
      logic [63:0] mb;
      logic [63:0] me;
      mb = m_mon_base >> PAGE_SHIFT;
      me = (m_mon_base + m_mon_size) >> PAGE_SHIFT;
      m_hole_base = '1;
      m_hole_end  = '0;
      if (page <= m_context_page) begin
         m_hole_base = m_context_page;
         m_hole_end  = m_context_page + 64'd1;
      end
      if ((m_mon_size >> PAGE_SHIFT) != 0 && mb < m_hole_base && page < me) begin
         m_hole_base = mb;
         m_hole_end  = me;
      end
   endfunction

   // Work out every beat one accepted entry causes.
   function automatic void split_entry(logic [63:0] sp, logic [63:0] pc, logic [15:0] kind);
      logic [64:0] mon_sum;
      logic [63:0] b;
      logic [63:0] e;
      int          cap;
      int          n;
      bit          done;
      n    = 0;
      done = 0;
      if (m_phase == PH_STOP) begin
         push_range('0, '0, 1'b0, ST_STOPPED);
         close_entry();
         return;
      end
      if (m_phase != PH_RUN) begin
         mon_sum = {1'b0, m_mon_base} + {1'b0, m_mon_size};
         if (mon_sum[64]) begin
            m_phase = PH_STOP;
            push_range('0, '0, 1'b0, ST_ERROR);
            close_entry();
            return;
         end
         m_hole_base = m_context_page;
         m_hole_end  = m_context_page + 64'd1;
         if ((m_mon_size >> PAGE_SHIFT) != 0 && (m_mon_base >> PAGE_SHIFT) < m_context_page) begin
            m_hole_base = m_mon_base >> PAGE_SHIFT;
            m_hole_end  = mon_sum[63:0] >> PAGE_SHIFT;
         end
         m_prev_end = '0;
         m_emitted  = 0;
         m_phase    = PH_RUN;
      end
      cap = (int'(m_capacity) < MAX_RANGES_DEFAULT) ? int'(m_capacity) : MAX_RANGES_DEFAULT;
      if (m_emitted >= cap || pc == 0) begin
         m_phase = PH_STOP;
         push_range('0, '0, 1'b0, ST_END);
         close_entry();
         return;
      end
      e = sp + pc;
      if (sp < m_prev_end || e <= sp || kind > KIND_RESERVED) begin
         m_phase = PH_STOP;
         push_range('0, '0, 1'b0, ST_ERROR);
         close_entry();
         return;
      end
      if (kind == KIND_RESERVED) begin
         m_prev_end = e;
         emit_pages(sp, pc, 1'b1);
         close_entry();
         return;
      end
      b = sp;
      while (!done && n < MAX_RESULTS && m_emitted < cap) begin
         if (b >= m_hole_end)
            locate_hole(b);
         if (b < m_hole_end && e > m_hole_base) begin
            if (b < m_hole_base) begin
               emit_pages(b, m_hole_base - b, 1'b0);
               m_prev_end = b;
               b = m_hole_base;
            end else if (e <= m_hole_end) begin
               emit_pages(b, e - b, 1'b1);
               m_prev_end = e;
               done = 1;
            end else begin
               emit_pages(b, m_hole_end - b, 1'b1);
               b = m_hole_end;
               m_prev_end = m_hole_end;
            end
         end else begin
            emit_pages(b, e - b, 1'b0);
            m_prev_end = e;
            done = 1;
         end
         n++;
      end
      close_entry();
   endfunction

   // ---------------------------------------------------------------
   // Clock, reset, pacing helpers
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Receiver: random stalls, or a forced hold-off counted down here.
   initial begin : rsp_pacing
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rx_hold > 0) begin
            rsp_ready <= 1'b0;
            rx_hold--;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
            stall = pick_gap();
            rsp_ready <= (stall == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // Check each result beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ranges.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: base %h len %h resv %b st %0d cnt %0d last %b",
                        rsp_base_address, rsp_length_bytes, rsp_is_reserved, rsp_status,
                        rsp_ranges_emitted, rsp_last);
         end else begin
            range_beat_type x;
            x = expected_ranges.pop_front();
            if (rsp_base_address !== x.base || rsp_length_bytes !== x.len
                || rsp_is_reserved !== x.resv || rsp_status !== x.status
                || rsp_ranges_emitted !== x.count || rsp_last !== x.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp: base %h len %h resv %b st %0d cnt %0d last %b",
                           x.base, x.len, x.resv, x.status, x.count, x.last);
                  $display("         got: base %h len %h resv %b st %0d cnt %0d last %b",
                           rsp_base_address, rsp_length_bytes, rsp_is_reserved, rsp_status,
                           rsp_ranges_emitted, rsp_last);
               end
            end
         end
      end
   end

   // Watchdog: trip when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Driving tasks
   // ---------------------------------------------------------------
   // Offer one entry, hold it until accepted, then predict its beats.
   task automatic send_entry(logic [63:0] sp, logic [63:0] pc, logic [15:0] kind);
      int gap;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_start_page <= sp;
      req_page_total <= pc;
      req_entry_kind <= kind;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      split_entry(sp, pc, kind);
   endtask

   // Send a sorted entry and advance the cursor past it.
   task automatic send_sorted(logic [63:0] sp, logic [63:0] pc, logic [15:0] kind);
      send_entry(sp, pc, kind);
      next_page = sp + pc;
   endtask

   // Drop valid, drain everything owed, then allow for trailing work.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_ranges.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      case (idx)
         CSR_CONTEXT_PAGE: m_context_page = value;
         CSR_MONITOR_BASE: m_mon_base     = value;
         CSR_MONITOR_SIZE: m_mon_size     = value;
         default:          m_capacity     = value[12:0];
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Hand-picked entries around the context page and the monitor region.
   task automatic test_directed();
      tx_steady = 1;
      write_csr(CSR_CONTEXT_PAGE, 64'h100);
      write_csr(CSR_MONITOR_BASE, 64'h8_0123);       // page 0x80, odd low bytes
      write_csr(CSR_MONITOR_SIZE, 64'h1_0000);       // 16 pages
      write_csr(CSR_RANGE_CAP, 64'h1FFF);            // above the hard limit
      send_sorted(64'h0, 64'h10, KIND_MEMORY);       // clear of both holes
      send_sorted(64'h10, 64'h8, KIND_RESERVED);     // passes through whole
      send_sorted(64'h70, 64'h190, KIND_MEMORY);     // five-way split
      send_sorted(64'h200, 64'h1, KIND_MEMORY);
      wait_idle();
      write_csr(CSR_CONTEXT_PAGE, 64'h400);
      write_csr(CSR_MONITOR_BASE, 64'h30_0000);      // pages 0x300..0x310
      send_sorted(64'h2F0, 64'h20, KIND_MEMORY);     // ends right at the hole end
      send_sorted(64'h310, 64'h10, KIND_MEMORY);
      send_sorted(64'h3FF, 64'h1, KIND_MEMORY);
      send_sorted(64'h400, 64'h1, KIND_MEMORY);      // exactly the context page
      send_sorted(64'h401, 64'h1, KIND_RESERVED);
      send_sorted(64'h402, 64'h1, KIND_MEMORY);
      wait_idle();
      write_csr(CSR_MONITOR_SIZE, 64'hFFF);          // under a page: no region
      write_csr(CSR_CONTEXT_PAGE, 64'h405);
      send_sorted(64'h403, 64'h4, KIND_MEMORY);      // starts below, ends past the context page
      send_sorted(64'h407, 64'h3, KIND_MEMORY);
      tx_steady = 0;
   endtask

   // Batches of sorted entries with holes moved ahead of the cursor each time.
   task automatic test_random_map(int batches, int per_batch);
      logic [63:0] sp;
      logic [63:0] pc;
      for (int bt = 0; bt < batches; bt++) begin
         wait_idle();
         rx_steady = (bt == 2);
         tx_steady = (bt == 2);
         write_csr(CSR_CONTEXT_PAGE, next_page + $urandom_range(0, 150));
         write_csr(CSR_MONITOR_BASE, ((next_page + $urandom_range(0, 150)) << PAGE_SHIFT)
                                     + $urandom_range(0, 4095));
         write_csr(CSR_MONITOR_SIZE, ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 4095))
                   : 64'($urandom_range(1, 40)) << PAGE_SHIFT);
         for (int i = 0; i < per_batch; i++) begin
            sp = next_page + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
            pc = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 20);
            send_sorted(sp, pc, ($urandom_range(0, 4) == 0) ? KIND_RESERVED : KIND_MEMORY);
         end
      end
      rx_steady = 0;
      tx_steady = 0;
   endtask

   // Hold the receiver off so the queue fills and the input stalls.
   task automatic test_backpressure();
      wait_idle();
      write_csr(CSR_CONTEXT_PAGE, next_page + 5);
      write_csr(CSR_MONITOR_BASE, (next_page + 20) << PAGE_SHIFT);
      write_csr(CSR_MONITOR_SIZE, 64'h4000);
      tx_steady = 1;
      rx_hold = 200;
      for (int i = 0; i < 30; i++)
         send_sorted(next_page, $urandom_range(2, 12), KIND_MEMORY);
      tx_steady = 0;
   endtask

   // Jump to the top of the page space; monitor registers take extremes.
   task automatic test_high_pages();
      wait_idle();
      write_csr(CSR_MONITOR_BASE, 64'h0);
      write_csr(CSR_MONITOR_SIZE, '1);               // region spans pages below 2^52 - 1
      write_csr(CSR_CONTEXT_PAGE, '1);               // reserves nothing
      send_sorted(next_page, 64'h8000_0000_0000_1234, KIND_MEMORY);
      send_sorted(next_page + 64'h5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA, KIND_MEMORY);
      wait_idle();
      write_csr(CSR_MONITOR_BASE, 64'hFFFF_FFFF_FFFF_F000);
      write_csr(CSR_MONITOR_SIZE, 64'hFFF);
      write_csr(CSR_CONTEXT_PAGE, next_page + 7);
      send_sorted(next_page, 64'h3, KIND_RESERVED);
      send_sorted(next_page, 64'h10, KIND_MEMORY);   // splits around the context page
      send_sorted(next_page + 1, 64'h1_0000_0000, KIND_MEMORY);
   endtask

   // Cap the range count mid-entry, end the map, then feed a stopped block.
   task automatic test_capacity_stop();
      logic [63:0] sp;
      wait_idle();
      write_csr(CSR_CONTEXT_PAGE, next_page + 4);
      write_csr(CSR_RANGE_CAP, 13'(m_emitted + 2));
      sp = next_page;
      send_sorted(sp, '1 - sp, KIND_MEMORY);         // ends at the last page, rest dropped
      send_entry(sp + 64'h100, 64'h5, KIND_MEMORY);  // map ends unexamined
      for (int i = 0; i < 20; i++)
         send_entry({$urandom, $urandom}, ($urandom_range(0, 3) == 0) ? 64'h0
                    : {$urandom, $urandom}, 16'($urandom));
      wait_idle();
      write_csr(CSR_RANGE_CAP, 64'h0);
      send_entry(64'h0, 64'h1, KIND_MEMORY);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_start_page = '0;
      req_page_total = '0;
      req_entry_kind = '0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_CONTEXT_PAGE;
      csr_wdata      = '0;
      m_context_page = '0;
      m_mon_base     = '0;
      m_mon_size     = '0;
      m_capacity     = RANGE_CAPACITY_RESET;
      m_prev_end     = '0;
      m_hole_base    = '0;
      m_hole_end     = '0;
      m_emitted      = 0;
      m_phase        = PH_FRESH;
      mismatches     = 0;
      idle_cycles    = 0;
      next_page      = '0;
      tx_steady      = 0;
      rx_steady      = 0;
      rx_hold        = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_map(5, 25);
      test_backpressure();
      test_random_map(3, 25);
      test_high_pages();
      test_capacity_stop();

      wait_idle();
      if (mismatches == 0 && expected_ranges.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
